### rtl/srng_pkg.sv
// ----------------------------------------------------------------------------
// srng_pkg
// Shared constants, types and helpers for the shuffled minimal standard
// generator: modulus arithmetic, slot selection and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package srng_pkg;

  localparam int DATA_W      = 31;
  localparam int SEED_W      = 32;
  localparam int MULT_W      = 15;
  localparam int PROD_W      = SEED_W + MULT_W;
  localparam int TABLE_DEPTH = 32;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int STEP_W      = 6;

  localparam logic [MULT_W-1:0] MINSTD_MULT = 15'd16807;
  localparam logic [DATA_W-1:0] MINSTD_MOD  = 31'h7FFF_FFFF;
  // last warm-up step index; steps below TABLE_DEPTH fill the table
  localparam logic [STEP_W-1:0] WARMUP_LAST = 6'd39;
  // slot divisor is 2^SLOT_SHIFT + 1 = 67108865
  localparam int SLOT_SHIFT = 26;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WMUL,
    ST_WFOLD,
    ST_DMUL,
    ST_DFOLD,
    ST_SEND
  } srng_state_t;

  // product mod (2^31 - 1); product < 16807 * 2^31 + 1
  function automatic logic [DATA_W-1:0] minstd_fold(input logic [PROD_W-1:0] prod);
    logic [SEED_W-1:0] sum;
    sum = {1'b0, prod[DATA_W-1:0]}
        + {{(SEED_W-PROD_W+DATA_W){1'b0}}, prod[PROD_W-1:DATA_W]};
    if (sum >= {1'b0, MINSTD_MOD}) begin
      sum = sum - {1'b0, MINSTD_MOD};
    end
    return sum[DATA_W-1:0];
  endfunction

  // floor(x / (2^26 + 1)) for x < 2^31 - 1, masked to the table index
  function automatic logic [TABLE_AW-1:0] slot_of(input logic [DATA_W-1:0] x);
    logic [TABLE_AW-1:0] q0;
    q0 = x[DATA_W-1:SLOT_SHIFT];
    if (x[SLOT_SHIFT-1:0] < {{(SLOT_SHIFT-TABLE_AW){1'b0}}, q0}) begin
      q0 = q0 - 1'b1;
    end
    return q0;
  endfunction

endpackage

`default_nettype wire

### rtl/srng_if.sv
// ----------------------------------------------------------------------------
// srng_if
// Valid/ready channels of the generator: request, response and seed write.
// ----------------------------------------------------------------------------
`default_nettype none

interface srng_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface srng_rsp_if
  import srng_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

interface srng_cfg_if
  import srng_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SEED_W-1:0] seed_value;

  modport source (output valid, output seed_value, input ready);
  modport sink   (input valid, input seed_value, output ready);
endinterface

`default_nettype wire

### rtl/srng_ram.sv
// ----------------------------------------------------------------------------
// srng_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srng_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/srng_mulmod.sv
// ----------------------------------------------------------------------------
// srng_mulmod
// Shared generator step: registered 16807 * x, then fold mod 2^31 - 1.
// ----------------------------------------------------------------------------
`default_nettype none

module srng_mulmod
  import srng_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic [SEED_W-1:0] operand,
  output logic      [DATA_W-1:0] result
);

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= {{MULT_W{1'b0}}, operand} * {{SEED_W{1'b0}}, MINSTD_MULT};
    end
  end

  assign result = minstd_fold(prod);

endmodule

`default_nettype wire

### rtl/shuffled_minimal_standard_rng.sv
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_rng
// Minimal standard generator feeding a 32-entry shuffle table.
//
//   channel  dir  payload              notes
//   cfg      in   seed_value   [31:0]  always ready, write only when idle
//   req      in   restart      [0]     one word per draw
//   rsp      out  random_value [30:0]  one word per request
//
// A draw passes from acceptance once through the shared multiply/fold unit
// (DMUL, DFOLD) with the table read and write, then the send step. req.ready
// returns with rsp.valid, so a new request is taken only after the previous
// response is issued. A restart (or the first draw after reset) adds 40
// warm-up steps through the same unit. req.ready is high only in idle.
// A waiting response holds the next draw in its send step; reset is
// synchronous and leaves the table unwritten.
// ----------------------------------------------------------------------------
`default_nettype none

module shuffled_minimal_standard_rng
  import srng_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  srng_cfg_if.sink   cfg,
  srng_req_if.sink   req,
  srng_rsp_if.source rsp
);

  srng_state_t         state, state_next;
  logic [SEED_W-1:0]   seed;
  logic [SEED_W-1:0]   work, work_next;
  logic [STEP_W-1:0]   step, step_next;
  logic [DATA_W-1:0]   gen, gen_next;
  logic [DATA_W-1:0]   last, last_next;
  logic [TABLE_AW-1:0] slot, slot_next;
  logic                primed, primed_next;
  logic                out_valid, out_valid_next;
  logic [DATA_W-1:0]   out_data, out_data_next;

  logic                mul_load;
  logic [SEED_W-1:0]   mul_operand;
  logic [DATA_W-1:0]   mul_result;
  logic                ram_we;
  logic [TABLE_AW-1:0] ram_waddr;
  logic                ram_re;
  logic [DATA_W-1:0]   ram_rdata;
  logic [SEED_W-1:0]   seed_mag;

  assign cfg.ready        = 1'b1;
  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= {{(SEED_W-1){1'b0}}, 1'b1};
    end else if (cfg.valid) begin
      seed <= cfg.seed_value;
    end
  end

  // magnitude, kept in 32 bits so the most negative seed stays 2^31
  always_comb begin
    seed_mag = seed[SEED_W-1] ? (~seed + 1'b1) : seed;
    if (seed_mag == '0) begin
      seed_mag = {{(SEED_W-1){1'b0}}, 1'b1};
    end
  end

  srng_mulmod u_mulmod (
    .clk     (clk),
    .load    (mul_load),
    .operand (mul_operand),
    .result  (mul_result)
  );

  srng_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (mul_result),
    .re    (ram_re),
    .raddr (slot_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      primed    <= 1'b0;
      out_valid <= 1'b0;
      gen       <= '0;
      last      <= '0;
    end else begin
      state     <= state_next;
      primed    <= primed_next;
      out_valid <= out_valid_next;
      gen       <= gen_next;
      last      <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    work     <= work_next;
    step     <= step_next;
    slot     <= slot_next;
    out_data <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    work_next      = work;
    step_next      = step;
    gen_next       = gen;
    last_next      = last;
    slot_next      = slot;
    primed_next    = primed;
    out_valid_next = out_valid && !rsp.ready;
    out_data_next  = out_data;
    mul_load       = 1'b0;
    mul_operand    = work;
    ram_we         = 1'b0;
    ram_waddr      = slot;
    ram_re         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.restart || !primed) begin
            work_next  = seed_mag;
            step_next  = WARMUP_LAST;
            state_next = ST_WMUL;
          end else begin
            state_next = ST_DMUL;
          end
        end
      end
      ST_WMUL: begin
        mul_load   = 1'b1;
        state_next = ST_WFOLD;
      end
      ST_WFOLD: begin
        work_next = {1'b0, mul_result};
        ram_we    = (step[STEP_W-1:TABLE_AW] == '0);
        ram_waddr = step[TABLE_AW-1:0];
        if (step == '0) begin
          gen_next    = mul_result;
          last_next   = mul_result;
          primed_next = 1'b1;
          state_next  = ST_DMUL;
        end else begin
          step_next  = step - 1'b1;
          state_next = ST_WMUL;
        end
      end
      ST_DMUL: begin
        mul_load    = 1'b1;
        mul_operand = {1'b0, gen};
        slot_next   = slot_of(last);
        ram_re      = 1'b1;
        state_next  = ST_DFOLD;
      end
      ST_DFOLD: begin
        gen_next   = mul_result;
        last_next  = ram_rdata;
        ram_we     = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_data_next  = last;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/srng_chk.sv
// ----------------------------------------------------------------------------
// srng_chk
// Port-level checks for the generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srng_chk
  import srng_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] out_value
);

  logic [1:0] pend, pend_next;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_next = pend;
    if (in_acc && !out_acc) begin
      pend_next = pend + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_next = pend - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("response word changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 2'd0)
    else $error("response word without a request");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("request taken while a draw is in progress");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_value != MINSTD_MOD)
    else $error("response word equals the modulus");

endmodule

bind shuffled_minimal_standard_rng srng_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_value (rsp.random_value)
);

`default_nettype wire
